// ===== hdl/checkerboard_pixel_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Checkerboard pixel generator assertion macros
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHECKERBOARD_PIXEL_GENERATOR_ASSERT_SVH
`define CHECKERBOARD_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define CBPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CBPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Checkerboard pixel generator package
// Shared widths, register indexes, luma constants and the division cell payload.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_W      = 13;
  localparam int OFFSET_W   = 13;
  localparam int COLOR_W    = 32;
  localparam int GRAY_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_EN   = 1'd1;

  localparam logic [DIV_W-1:0] CELL_SIZE_RESET = 13'd1;

  localparam int LUMA_SUM_W   = 18;
  localparam int LUMA_RECIP_W = 19;
  localparam int LUMA_PROD_W  = LUMA_SUM_W + LUMA_RECIP_W;
  localparam int LUMA_SHIFT   = 28;

  localparam logic [LUMA_SUM_W-1:0]   LUMA_WR    = 18'd299;
  localparam logic [LUMA_SUM_W-1:0]   LUMA_WG    = 18'd587;
  localparam logic [LUMA_SUM_W-1:0]   LUMA_WB    = 18'd114;
  // ceil(2^28 / 1000), exact floor for every weighted sum up to 255000
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic               q_x;
    logic               q_y;
    logic [DIV_W-1:0]   rem_x;
    logic [DIV_W-1:0]   rem_y;
    logic [COLOR_W-1:0] first_color;
    logic [COLOR_W-1:0] second_color;
  } cbpg_cell_t;

endpackage

// ===== hdl/cbpg_div_cell.sv =====
// ----------------------------------------------------------------------------
// Checkerboard division cell
// One restoring division step for both coordinates, registered toward the next cell.
// ----------------------------------------------------------------------------
module cbpg_div_cell #(
  parameter int MAG_W   = 13,
  parameter int BIT_IDX = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic                           valid_i,
  input  cbpg_pkg::cbpg_cell_t           cell_i,
  input  logic [MAG_W-1:0]               mag_x_i,
  input  logic [MAG_W-1:0]               mag_y_i,
  input  logic [cbpg_pkg::DIV_W-1:0]     divisor_i,
  output logic                           valid_o,
  output cbpg_pkg::cbpg_cell_t           cell_o,
  output logic [MAG_W-1:0]               mag_x_o,
  output logic [MAG_W-1:0]               mag_y_o
);

  import cbpg_pkg::*;

  logic [DIV_W:0]   div_ext;
  logic [DIV_W:0]   trial_x;
  logic [DIV_W:0]   trial_y;
  logic             q_x;
  logic             q_y;
  cbpg_cell_t       cell_d;
  cbpg_cell_t       cell_q;
  logic             valid_q;
  logic [MAG_W-1:0] mag_x_q;
  logic [MAG_W-1:0] mag_y_q;

  always_comb begin
    div_ext = {1'b0, divisor_i};
    trial_x = {cell_i.rem_x, mag_x_i[BIT_IDX]};
    trial_y = {cell_i.rem_y, mag_y_i[BIT_IDX]};
    q_x     = (trial_x >= div_ext);
    q_y     = (trial_y >= div_ext);
    cell_d  = cell_i;
    cell_d.q_x   = q_x;
    cell_d.q_y   = q_y;
    cell_d.rem_x = q_x ? DIV_W'(trial_x - div_ext) : trial_x[DIV_W-1:0];
    cell_d.rem_y = q_y ? DIV_W'(trial_y - div_ext) : trial_y[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      cell_q  <= cell_d;
      mag_x_q <= mag_x_i;
      mag_y_q <= mag_y_i;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;
  assign mag_x_o = mag_x_q;
  assign mag_y_o = mag_y_q;

endmodule

// ===== hdl/cbpg_luma.sv =====
// ----------------------------------------------------------------------------
// Checkerboard luma tail
// Weighted RGB sum, then reciprocal multiply into the output register.
// ----------------------------------------------------------------------------
`include "checkerboard_pixel_generator_assert.svh"

module cbpg_luma (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          valid_i,
  input  logic [cbpg_pkg::COLOR_W-1:0]  color_i,
  output logic                          valid_o,
  output logic [cbpg_pkg::COLOR_W-1:0]  color_o,
  output logic [cbpg_pkg::GRAY_W-1:0]   gray_o
);

  import cbpg_pkg::*;

  logic [7:0]             r;
  logic [7:0]             g;
  logic [7:0]             b;
  logic [LUMA_SUM_W-1:0]  sum_d;
  logic [LUMA_SUM_W-1:0]  sum_q;
  logic [COLOR_W-1:0]     color_a_q;
  logic                   valid_a_q;
  logic [LUMA_PROD_W-1:0] prod;
  logic                   valid_q;
  logic [COLOR_W-1:0]     color_q;
  logic [GRAY_W-1:0]      gray_q;

  always_comb begin
    r     = color_i[31:24];
    g     = color_i[23:16];
    b     = color_i[15:8];
    sum_d = LUMA_WR * LUMA_SUM_W'(r) + LUMA_WG * LUMA_SUM_W'(g) + LUMA_WB * LUMA_SUM_W'(b);
    prod  = LUMA_PROD_W'(sum_q) * LUMA_PROD_W'(LUMA_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (advance_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sum_q     <= sum_d;
      color_a_q <= color_i;
      color_q   <= color_a_q;
      gray_q    <= prod[LUMA_SHIFT +: GRAY_W];
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;
  assign gray_o  = gray_q;

  `CBPG_ASSERT_NEXT(a_sum_reaches_out, valid_a_q && advance_i, valid_q, "luma stage dropped a pixel")
  `CBPG_ASSERT_NOW(a_sum_in_range, valid_a_q, sum_q <= 18'd255000, "luma sum out of range")

endmodule

// ===== hdl/checkerboard_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// Checkerboard pixel generator
// Picks one of two colors per pixel from the checker cell parity and adds luma.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall_o is low and returns one result per
// pixel, in order, through a chain of max(COORD_WIDTH + 1, 13) division cells,
// one quotient bit per cell for both coordinates, then a luma sum stage and the
// output register. The whole chain advances whenever the output register is
// empty or being taken, so a pixel enters on every such cycle. The user must keep
// cell size and distortion enable static while pixels are in flight; the block
// does not enforce it. A cell size of zero is stored as one.
`include "checkerboard_pixel_generator_assert.svh"

module checkerboard_pixel_generator #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbpg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cbpg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_WIDTH-1:0]           pixel_x_i,
  input  logic [COORD_WIDTH-1:0]           pixel_y_i,
  input  logic signed [cbpg_pkg::OFFSET_W-1:0] offset_x_i,
  input  logic signed [cbpg_pkg::OFFSET_W-1:0] offset_y_i,
  input  logic [cbpg_pkg::COLOR_W-1:0]     first_color_i,
  input  logic [cbpg_pkg::COLOR_W-1:0]     second_color_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cbpg_pkg::COLOR_W-1:0]     result_color_o,
  output logic [cbpg_pkg::GRAY_W-1:0]      result_gray_o
);

  import cbpg_pkg::*;

  localparam int SumW = ((COORD_WIDTH + 1 > OFFSET_W) ? COORD_WIDTH + 1 : OFFSET_W) + 1;
  localparam int MagW = SumW - 1;

  logic [DIV_W-1:0]       cell_size_q;
  logic                   dist_en_q;
  logic                   advance;

  logic signed [SumW-1:0] px_ext;
  logic signed [SumW-1:0] py_ext;
  logic signed [SumW-1:0] ox_ext;
  logic signed [SumW-1:0] oy_ext;
  logic signed [SumW-1:0] dist_x;
  logic signed [SumW-1:0] dist_y;
  logic                   neg_x;
  logic                   neg_y;
  logic [MagW-1:0]        mag_x;
  logic [MagW-1:0]        mag_y;

  cbpg_cell_t             cell_pl [MagW+1];
  logic                   cell_vld [MagW+1];
  logic [MagW-1:0]        mag_x_a [MagW+1];
  logic [MagW-1:0]        mag_y_a [MagW+1];

  cbpg_cell_t             tail;
  logic                   parity;
  logic [COLOR_W-1:0]     sel_color;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RESET;
      dist_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELL_SIZE: begin
          cell_size_q <= (cfg_data_i == '0) ? CELL_SIZE_RESET : DIV_W'(cfg_data_i);
        end
        CFG_DIST_EN: begin
          dist_en_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // flow control
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  // distort and fold negatives into a one's complement magnitude
  always_comb begin
    px_ext = signed'({{(SumW - COORD_WIDTH){1'b0}}, pixel_x_i});
    py_ext = signed'({{(SumW - COORD_WIDTH){1'b0}}, pixel_y_i});
    ox_ext = signed'({{(SumW - OFFSET_W){offset_x_i[OFFSET_W-1]}}, offset_x_i});
    oy_ext = signed'({{(SumW - OFFSET_W){offset_y_i[OFFSET_W-1]}}, offset_y_i});
    dist_x = px_ext + (dist_en_q ? ox_ext : '0);
    dist_y = py_ext + (dist_en_q ? oy_ext : '0);
    neg_x  = dist_x[SumW-1];
    neg_y  = dist_y[SumW-1];
    mag_x  = neg_x ? ~dist_x[MagW-1:0] : dist_x[MagW-1:0];
    mag_y  = neg_y ? ~dist_y[MagW-1:0] : dist_y[MagW-1:0];
  end

  assign cell_vld[0] = in_valid_i;
  assign mag_x_a[0]  = mag_x;
  assign mag_y_a[0]  = mag_y;
  assign cell_pl[0]  = '{neg_x: neg_x, neg_y: neg_y, q_x: 1'b0, q_y: 1'b0,
                         rem_x: '0, rem_y: '0, first_color: first_color_i,
                         second_color: second_color_i};

  for (genvar g = 0; g < MagW; g++) begin : g_cell
    cbpg_div_cell #(
      .MAG_W   (MagW),
      .BIT_IDX (MagW - 1 - g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (cell_vld[g]),
      .cell_i    (cell_pl[g]),
      .mag_x_i   (mag_x_a[g]),
      .mag_y_i   (mag_y_a[g]),
      .divisor_i (cell_size_q),
      .valid_o   (cell_vld[g+1]),
      .cell_o    (cell_pl[g+1]),
      .mag_x_o   (mag_x_a[g+1]),
      .mag_y_o   (mag_y_a[g+1])
    );
  end

  // floor(n/d) for negative n is -(~n / d) - 1, which flips the parity
  assign tail      = cell_pl[MagW];
  assign parity    = tail.q_x ^ tail.q_y ^ tail.neg_x ^ tail.neg_y;
  assign sel_color = parity ? tail.second_color : tail.first_color;

  cbpg_luma u_luma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (cell_vld[MagW]),
    .color_i   (sel_color),
    .valid_o   (out_valid_o),
    .color_o   (result_color_o),
    .gray_o    (result_gray_o)
  );

  `CBPG_ASSERT_NOW(a_size_nonzero, 1'b1, cell_size_q != '0, "cell size register holds zero")
  `CBPG_ASSERT_NOW(a_stall_only_full, in_stall_o, out_valid_o, "input stalled with empty output")
  `CBPG_ASSERT_NEXT(a_hold_when_stalled, in_stall_o, $stable(cell_vld[MagW]), "chain moved while stalled")

endmodule

// ===== dv/checkerboard_pixel_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Checkerboard pixel generator testbench
// Streams pixels through the block under several cell size and distortion
// settings, predicts each selected color and its luma, and compares every
// output transaction in order against the predicted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checkerboard_pixel_generator_tb;
  import cbpg_pkg::*;

  localparam int COORD_W = 12;
  localparam int LATENCY = COORD_W + 4;

  typedef struct packed {
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic signed [OFFSET_W-1:0] off_x;
    logic signed [OFFSET_W-1:0] off_y;
    logic [COLOR_W-1:0]         even_color;
    logic [COLOR_W-1:0]         odd_color;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [GRAY_W-1:0]  gray;
  } shade_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = CFG_CELL_SIZE;
  logic [CFG_DATA_W-1:0]       cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [COORD_W-1:0]          pixel_x_i = '0;
  logic [COORD_W-1:0]          pixel_y_i = '0;
  logic signed [OFFSET_W-1:0]  offset_x_i = '0;
  logic signed [OFFSET_W-1:0]  offset_y_i = '0;
  logic [COLOR_W-1:0]          first_color_i = '0;
  logic [COLOR_W-1:0]          second_color_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [COLOR_W-1:0]          result_color_o;
  logic [GRAY_W-1:0]           result_gray_o;

  pixel_t             pixel_q[$];
  shade_t             shade_q[$];
  pixel_t             cur_pixel;
  logic [DIV_W-1:0]   cell_sz_q = CELL_SIZE_RESET;
  logic               distort_en_q = 1'b0;
  int                 err_count = 0;
  int                 burst_left = 8;
  int                 gap_left = 0;
  int                 stall_cnt = 0;
  int                 stall_mode = 0;

  checkerboard_pixel_generator #(
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .first_color_i (first_color_i),
    .second_color_i(second_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_color_o(result_color_o),
    .result_gray_o (result_gray_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int floor_cell(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic shade_t shade_pixel(pixel_t p, logic [DIV_W-1:0] cell_sz, logic distort_en);
    int     px, py, d, cell_sum, r, g, b;
    shade_t s;
    px = int'(p.x);
    py = int'(p.y);
    d = (cell_sz == '0) ? 1 : int'(cell_sz);
    if (distort_en) begin
      px = px + int'(p.off_x);
      py = py + int'(p.off_y);
    end
    cell_sum = floor_cell(px, d) + floor_cell(py, d);
    s.color = cell_sum[0] ? p.odd_color : p.even_color;
    r = int'(s.color[31:24]);
    g = int'(s.color[23:16]);
    b = int'(s.color[15:8]);
    s.gray = GRAY_W'((299 * r + 587 * g + 114 * b) / 1000);
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return COORD_W'($urandom_range(0, 31));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [OFFSET_W-1:0] rand_offset();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(OFFSET_W-1){1'b0}}};
      1: return {1'b0, {(OFFSET_W-1){1'b1}}};
      2, 3: return OFFSET_W'($urandom_range(0, 16) - 8);
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  task automatic add_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic signed [OFFSET_W-1:0] ox,
                           input logic signed [OFFSET_W-1:0] oy,
                           input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1);
    pixel_t p;
    p = '{x, y, ox, oy, c0, c1};
    pixel_q.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CELL_SIZE) cell_sz_q = data;
    else distort_en_q = data[0];
  endtask

  // hold until every queued pixel is sent and every result is back
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid_i || shade_q.size() != 0) @(posedge clk_i);
  endtask

  // driver: bursts of pixels separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) shade_q.push_back(shade_pixel(cur_pixel, cell_sz_q,
                                                                   distort_en_q));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          cur_pixel = pixel_q[0];
          pixel_q.delete(0);
          in_valid_i     <= 1'b1;
          pixel_x_i      <= cur_pixel.x;
          pixel_y_i      <= cur_pixel.y;
          offset_x_i     <= cur_pixel.off_x;
          offset_y_i     <= cur_pixel.off_y;
          first_color_i  <= cur_pixel.even_color;
          second_color_i <= cur_pixel.odd_color;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // output stall pattern: switch to a random mode whenever the hold counter runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt = $urandom_range(20, 200);
      end else begin
        stall_cnt = stall_cnt - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 9) < 8);
        default: out_stall_i <= (stall_cnt % 8) < 3;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    shade_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shade_q.size() == 0) begin
        $error("unexpected result transaction: color %h gray %0d", result_color_o, result_gray_o);
        err_count++;
      end else begin
        want = shade_q.pop_front();
        if (result_color_o !== want.color) begin
          $error("result_color: expected %h, got %h", want.color, result_color_o);
          err_count++;
        end
        if (result_gray_o !== want.gray) begin
          $error("result_gray: expected %0d, got %0d", want.gray, result_gray_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [DIV_W-1:0] sz;
    logic             en;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: unit cells, offsets ignored
    add_pixel('0, '0, 13'sh1000, 13'sh0fff, 32'h0000_0000, 32'hffff_ffff);
    add_pixel('1, '0, 13'sh0fff, 13'sh1000, 32'h0000_0000, 32'hffff_ffff);
    add_pixel('0, '1, -13'sd1, -13'sd1, 32'hffff_ffff, 32'h0000_0000);
    add_pixel('1, '1, 13'sd5, 13'sd0, 32'hffff_ffff, 32'h0000_0000);
    add_pixel(12'd1, 12'd2, 13'sd0, 13'sd0, 32'h0000_00ff, 32'hff00_0000);
    add_pixel(12'd2, 12'd2, 13'sd1, 13'sd0, 32'h00ff_0000, 32'h0000_ff00);
    drain();

    // zero cell size behaves as one, negative distorted coordinates
    write_reg(CFG_CELL_SIZE, '0);
    write_reg(CFG_DIST_EN, 13'd1);
    add_pixel('0, '0, -13'sd1, 13'sd0, 32'h1122_3344, 32'h5566_7788);
    add_pixel('0, '0, -13'sd1, -13'sd1, 32'h1122_3344, 32'h5566_7788);
    add_pixel('0, '0, 13'sh1000, 13'sh1000, 32'haabb_ccdd, 32'h0102_0304);
    add_pixel('1, '1, 13'sh0fff, 13'sh1000, 32'haabb_ccdd, 32'h0102_0304);
    add_pixel(12'd3, '0, -13'sd6, -13'sd2, 32'hffff_ff00, 32'h8080_8080);
    drain();

    // largest cell size, floor toward minus infinity
    write_reg(CFG_CELL_SIZE, 13'h1fff);
    add_pixel('0, '0, -13'sd1, 13'sd0, 32'hdead_beef, 32'hcafe_f00d);
    add_pixel('1, '1, 13'sh0fff, 13'sh0fff, 32'hdead_beef, 32'hcafe_f00d);
    add_pixel('0, '1, 13'sh1000, 13'sh0fff, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    add_pixel('1, '0, 13'sd0, 13'sh1000, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    drain();

    // cell size of a full line, distortion off again
    write_reg(CFG_DIST_EN, 13'd0);
    write_reg(CFG_CELL_SIZE, 13'd4096);
    add_pixel('1, '1, 13'sh0fff, -13'sd4, 32'h1234_5678, 32'h9abc_def0);
    add_pixel(12'd7, 12'd9, 13'sh1000, 13'sh1000, 32'h1234_5678, 32'h9abc_def0);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0: sz = '0;
        1: sz = 13'h1fff;
        2: sz = 13'd4096;
        3: sz = DIV_W'($urandom_range(0, 8191));
        4: sz = DIV_W'($urandom_range(17, 512));
        default: sz = DIV_W'($urandom_range(1, 16));
      endcase
      en = (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_CELL_SIZE, sz);
        write_reg(CFG_DIST_EN, {12'($urandom), en});
      end else begin
        write_reg(CFG_DIST_EN, {12'($urandom), en});
        write_reg(CFG_CELL_SIZE, sz);
      end
      for (int i = 0; i < 150; i++)
        add_pixel(rand_coord(), rand_coord(), rand_offset(), rand_offset(),
                  32'($urandom), 32'($urandom));
      drain();
    end

    repeat (3 * LATENCY) @(posedge clk_i);
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
